// ===== hdl/kana_width_case_folder_defines.svh =====
// Assertion macros for the kana width and case folder.
// Used by hdl/kana_width_case_folder.sv; needs clk and arst_n in scope.
`ifndef KANA_WIDTH_CASE_FOLDER_DEFINES_SVH
`define KANA_WIDTH_CASE_FOLDER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define KWCF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kwcf same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define KWCF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kwcf next-cycle check failed");

`endif

// ===== hdl/kwcf_pkg.sv =====
// Types, constants and folding functions of the kana width and case folder.
// No dependencies.
package kwcf_pkg;

	localparam int unsigned UnitW = 16;

	localparam logic [UnitW-1:0] FwAsciiOfs  = 16'hFEE0;
	localparam logic [UnitW-1:0] KanaOfs     = 16'h0060;
	localparam logic [UnitW-1:0] IdeoSpace   = 16'h3000;
	localparam logic [UnitW-1:0] HalfKanaLo  = 16'hFF61;
	localparam logic [UnitW-1:0] HalfKanaHi  = 16'hFF9D;
	localparam logic [UnitW-1:0] HalfVoiced  = 16'hFF9E;
	localparam logic [UnitW-1:0] HalfSemi    = 16'hFF9F;
	localparam logic [UnitW-1:0] FwAsciiLo   = 16'hFF01;
	localparam logic [UnitW-1:0] FwAsciiHi   = 16'hFF5E;
	localparam logic [UnitW-1:0] KataVu      = 16'h30F4;
	localparam logic [UnitW-1:0] KataU       = 16'h30A6;
	localparam logic [UnitW-1:0] SpVoiced    = 16'h309B;
	localparam logic [UnitW-1:0] SpSemi      = 16'h309C;
	localparam logic [UnitW-1:0] KataHa      = 16'h30CF;
	localparam logic [UnitW-1:0] KataKa      = 16'h30AB;
	localparam logic [UnitW-1:0] KataChi     = 16'h30C1;
	localparam logic [UnitW-1:0] KataTsu     = 16'h30C4;
	localparam logic [UnitW-1:0] KataTo      = 16'h30C8;
	localparam logic [UnitW-1:0] KataLo      = 16'h30A1;
	localparam logic [UnitW-1:0] KataHi      = 16'h30F6;
	localparam logic [5:0]       HalfIdxOfs  = 6'h21;

	typedef logic [UnitW-1:0] unit_t;

	typedef struct packed {
		logic  ok;
		unit_t unit;
	} fold_t;

	function automatic unit_t half_kana(input logic [5:0] idx);
		unit_t r;
		case (idx)
			6'd0:  r = 16'h3002; 6'd1:  r = 16'h300C; 6'd2:  r = 16'h300D;
			6'd3:  r = 16'h3001; 6'd4:  r = 16'h30FB; 6'd5:  r = 16'h30F2;
			6'd6:  r = 16'h30A1; 6'd7:  r = 16'h30A3; 6'd8:  r = 16'h30A5;
			6'd9:  r = 16'h30A7; 6'd10: r = 16'h30A9; 6'd11: r = 16'h30E3;
			6'd12: r = 16'h30E5; 6'd13: r = 16'h30E7; 6'd14: r = 16'h30C3;
			6'd15: r = 16'h30FC; 6'd16: r = 16'h30A2; 6'd17: r = 16'h30A4;
			6'd18: r = 16'h30A6; 6'd19: r = 16'h30A8; 6'd20: r = 16'h30AA;
			6'd21: r = 16'h30AB; 6'd22: r = 16'h30AD; 6'd23: r = 16'h30AF;
			6'd24: r = 16'h30B1; 6'd25: r = 16'h30B3; 6'd26: r = 16'h30B5;
			6'd27: r = 16'h30B7; 6'd28: r = 16'h30B9; 6'd29: r = 16'h30BB;
			6'd30: r = 16'h30BD; 6'd31: r = 16'h30BF; 6'd32: r = 16'h30C1;
			6'd33: r = 16'h30C4; 6'd34: r = 16'h30C6; 6'd35: r = 16'h30C8;
			6'd36: r = 16'h30CA; 6'd37: r = 16'h30CB; 6'd38: r = 16'h30CC;
			6'd39: r = 16'h30CD; 6'd40: r = 16'h30CE; 6'd41: r = 16'h30CF;
			6'd42: r = 16'h30D2; 6'd43: r = 16'h30D5; 6'd44: r = 16'h30D8;
			6'd45: r = 16'h30DB; 6'd46: r = 16'h30DE; 6'd47: r = 16'h30DF;
			6'd48: r = 16'h30E0; 6'd49: r = 16'h30E1; 6'd50: r = 16'h30E2;
			6'd51: r = 16'h30E4; 6'd52: r = 16'h30E6; 6'd53: r = 16'h30E8;
			6'd54: r = 16'h30E9; 6'd55: r = 16'h30EA; 6'd56: r = 16'h30EB;
			6'd57: r = 16'h30EC; 6'd58: r = 16'h30ED; 6'd59: r = 16'h30EF;
			6'd60: r = 16'h30F3;
			default: r = '0;
		endcase
		return r;
	endfunction

	// ha, hi, fu, he, ho rows take both marks
	function automatic logic is_ha_row(input unit_t b);
		return (b == KataHa) || (b == KataHa + 16'd3) || (b == KataHa + 16'd6) ||
			(b == KataHa + 16'd9) || (b == KataHa + 16'd12);
	endfunction

	function automatic fold_t voiced_of(input unit_t b);
		fold_t r;
		r.ok   = 1'b0;
		r.unit = b + 16'd1;
		if ((b >= KataKa && b <= KataChi && b[0]) ||
			(b >= KataTsu && b <= KataTo && !b[0]) || is_ha_row(b)) begin
			r.ok = 1'b1;
		end else if (b == KataU) begin
			r.ok   = 1'b1;
			r.unit = KataVu;
		end
		return r;
	endfunction

	function automatic fold_t semivoiced_of(input unit_t b);
		fold_t r;
		r.ok   = is_ha_row(b);
		r.unit = b + 16'd2;
		return r;
	endfunction

	function automatic fold_t fold_finish(input unit_t c);
		fold_t r;
		unit_t t;
		t = c;
		if (t >= 16'h0041 && t <= 16'h005A) t = t + 16'h0020;
		if (t >= KataLo && t <= KataHi) t = t - KanaOfs;
		r.ok   = !(c == IdeoSpace || c == 16'h0020 || c == 16'h0009 ||
			c == 16'h000D || c == 16'h000A);
		r.unit = t;
		return r;
	endfunction

endpackage

// ===== hdl/kana_width_case_folder.sv =====
// Kana width and case folder: one input register, folding logic, one result register.
// Depends on kwcf_pkg and kana_width_case_folder_defines.svh.
// The input register feeds the folding logic, whose result is registered; a halfwidth letter waits for the next item.
// Throughput: 1 item per cycle while out_ready holds; an item that releases a held letter and also
// emits its own unit stays in the input register for two results, bounded by the single result register.
// Reset: arst_n clears the input stage, the held letter and the result register.
`include "kana_width_case_folder_defines.svh"

module kana_width_case_folder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  kwcf_pkg::unit_t      code_unit,
	input  logic                 string_end,
	output logic                 out_valid,
	input  logic                 out_ready,
	output kwcf_pkg::unit_t      folded_unit,
	output logic                 unit_valid,
	output logic                 string_done,
	output logic                 run_last
);
	import kwcf_pkg::*;

	logic  valid_s1;
	unit_t unit_s1;
	logic  end_s1;

	logic  held_valid_q;
	unit_t held_letter_q;
	logic  phase_q;

	logic  out_valid_q;
	unit_t out_unit_q;
	logic  out_uv_q;
	logic  out_done_q;
	logic  out_last_q;

	logic  is_vm, is_sm, is_hk, is_fw;
	fold_t vo, so, f0, f1;
	logic  use_v, use_s, consumed;
	unit_t r0_src, cur_src, kana;
	logic  r0_v, r1_emit, marker, r1_p, any_res;
	logic  pick_r0, pick_last, out_free, emit, s1_done;

	always_comb begin
		is_vm   = (unit_s1 == HalfVoiced);
		is_sm   = (unit_s1 == HalfSemi);
		is_hk   = (unit_s1 >= HalfKanaLo) && (unit_s1 <= HalfKanaHi);
		is_fw   = (unit_s1 >= FwAsciiLo) && (unit_s1 <= FwAsciiHi);
		vo      = voiced_of(held_letter_q);
		so      = semivoiced_of(held_letter_q);
		use_v   = is_vm && vo.ok;
		use_s   = is_sm && so.ok;
		consumed = held_valid_q && (use_v || use_s);
		r0_src  = use_v ? vo.unit : (use_s ? so.unit : held_letter_q);
		f0      = fold_finish(r0_src);
		r0_v    = held_valid_q && f0.ok;
		kana    = half_kana(6'(unit_s1[5:0] - HalfIdxOfs));
		if (is_hk)
			cur_src = kana;
		else if (is_vm)
			cur_src = SpVoiced;
		else if (is_sm)
			cur_src = SpSemi;
		else if (is_fw)
			cur_src = unit_s1 - FwAsciiOfs;
		else
			cur_src = unit_s1;
		f1        = fold_finish(cur_src);
		r1_emit   = !consumed && !(is_hk && !end_s1) && f1.ok;
		marker    = end_s1 && !r0_v && !r1_emit;
		r1_p      = r1_emit || marker;
		any_res   = r0_v || r1_p;
		pick_r0   = !phase_q && r0_v;
		pick_last = pick_r0 ? !r1_p : 1'b1;
		out_free  = !out_valid_q || out_ready;
		emit      = valid_s1 && any_res && out_free;
		s1_done   = valid_s1 && (!any_res || (emit && pick_last));
	end

	assign in_ready = !valid_s1 || s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			held_valid_q  <= 1'b0;
			held_letter_q <= '0;
			phase_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (s1_done) begin
				held_valid_q  <= !consumed && is_hk && !end_s1;
				held_letter_q <= kana;
				phase_q       <= 1'b0;
			end else if (emit && pick_r0) begin
				phase_q <= 1'b1;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			unit_s1 <= code_unit;
			end_s1  <= string_end;
		end
		if (emit) begin
			out_unit_q <= pick_r0 ? f0.unit : (r1_emit ? f1.unit : '0);
			out_uv_q   <= pick_r0 || r1_emit;
			out_done_q <= pick_last && end_s1;
			out_last_q <= pick_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign folded_unit = out_unit_q;
	assign unit_valid  = out_uv_q;
	assign string_done = out_done_q;
	assign run_last    = out_last_q;

	`KWCF_ASSERT_IMPL(a_phase_has_item, phase_q, valid_s1)
	`KWCF_ASSERT_NEXT(a_end_clears_hold, s1_done && end_s1, !held_valid_q)
	`KWCF_ASSERT_IMPL(a_marker_flags, out_valid_q && !out_uv_q, out_done_q && out_last_q)
	`KWCF_ASSERT_IMPL(a_done_is_last, out_valid_q && out_done_q, out_last_q)

endmodule
